// File: rtl/dcsm_pkg.sv
package dcsm_pkg;

   localparam int SlotCountDefault = 15;

   localparam int TexW   = 31;
   localparam int IdxW   = 24;
   localparam int SlotW  = 4;
   localparam int ReqDataW  = 112;
   localparam int ReqUserW  = 1;
   localparam int RspDataW  = 64;

   localparam logic [IdxW-1:0] IdxMax = '1;

   typedef struct packed {
      logic            first_batch;
      logic            cull_enable;
      logic            two_textures;
      logic [TexW-1:0] texture_a;
      logic [TexW-1:0] texture_b;
      logic [IdxW-1:0] first_index;
      logic [IdxW-1:0] index_total;
   } batch_type;

   typedef struct packed {
      logic [SlotW-1:0] slot_a;
      logic [SlotW-1:0] slot_b;
      logic             opened_call;
      logic [IdxW-1:0]  call_first_index;
      logic [IdxW-1:0]  call_index_total;
      logic             call_cull;
      logic [SlotW-1:0] slots_in_use;
      logic             added_texture_a;
      logic             added_texture_b;
   } result_type;

endpackage

// File: rtl/draw_call_sampler_slot_merger_unit.sv
// An accepted req word reaches its rsp word via the input register, then the result register.
// Throughput: one batch per cycle unless rsp_tready stalls the output; the slot lookup is a
// parallel compare against all SLOT_COUNT slot registers, and the open call state updates at
// the same edge as the result. Reset (synchronous, active high) clears both valid flags and the
// open call; the slot table is not reset, only slots below the occupied count are ever compared.
module draw_call_sampler_slot_merger_unit
   import dcsm_pkg::*;
#(
   parameter int SLOT_COUNT = SlotCountDefault
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   // [0] cull_enable, [1] two_textures, [32:2] texture_a, [63:33] texture_b,
   // [87:64] first_index, [111:88] index_total
   input  logic [ReqDataW-1:0] req_tdata,
   // [0] first_batch
   input  logic [ReqUserW-1:0] req_tuser,

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [3:0] slot_a, [7:4] slot_b, [8] opened_call, [32:9] call_first_index,
   // [56:33] call_index_total, [57] call_cull, [61:58] slots_in_use,
   // [62] added_texture_a, [63] added_texture_b
   output logic [RspDataW-1:0] rsp_tdata
);

   localparam int CntW = $clog2(SLOT_COUNT + 1);
   localparam int AdrW = $clog2(SLOT_COUNT);
   localparam int ExtW = (CntW > SlotW) ? CntW : SlotW;

   // input and result registers
   logic       in_valid_ff, in_valid_in;
   batch_type  in_item_ff, in_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_item_ff, rsp_item_in;

   // open call state
   logic [TexW-1:0] slot_table_ff [SLOT_COUNT];
   logic [CntW-1:0] used_slots_ff, used_slots_in;
   logic            open_valid_ff, open_valid_in;
   logic [IdxW-1:0] open_start_ff, open_start_in;
   logic [IdxW-1:0] open_count_ff, open_count_in;
   logic            open_cull_ff, open_cull_in;

   logic                  advance;
   logic [SLOT_COUNT-1:0] hit_a, hit_b;
   logic                  found_a, found_b;
   logic [CntW-1:0]       pos_a, pos_b;
   logic [IdxW:0]         call_end;
   logic                  join_ok;
   logic [CntW-1:0]       avail;
   logic                  miss_a, miss_b, need_b;
   logic                  create;
   logic                  wr_a, wr_b;
   logic [CntW-1:0]       adr_a, adr_b;
   logic [TexW-1:0]       data_b;
   logic [CntW-1:0]       sa, sb, used_mid;
   logic                  add_a, add_b;
   logic [IdxW-1:0]       count_base;
   logic [IdxW:0]         count_sum;
   logic [ExtW-1:0]       sa_ext, sb_ext, used_ext;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in              = 1'b1;
         in_item_in.first_batch   = req_tuser[0];
         in_item_in.cull_enable   = req_tdata[0];
         in_item_in.two_textures  = req_tdata[1];
         in_item_in.texture_a     = req_tdata[32:2];
         in_item_in.texture_b     = req_tdata[63:33];
         in_item_in.first_index   = req_tdata[87:64];
         in_item_in.index_total   = req_tdata[111:88];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // parallel lookup over occupied slots, lowest matching slot wins
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit_a[i] = (CntW'(i) < used_slots_ff) && (slot_table_ff[i] == in_item_ff.texture_a);
         hit_b[i] = (CntW'(i) < used_slots_ff) && (slot_table_ff[i] == in_item_ff.texture_b);
      end
      pos_a = '0;
      pos_b = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (hit_a[i]) begin
            pos_a = CntW'(i);
         end
         if (hit_b[i]) begin
            pos_b = CntW'(i);
         end
      end
   end

   assign found_a = |hit_a;
   assign found_b = |hit_b;

   always_comb begin
      call_end = {1'b0, open_start_ff} + {1'b0, open_count_ff};
      join_ok  = open_valid_ff && !in_item_ff.first_batch &&
                 (open_cull_ff == in_item_ff.cull_enable) &&
                 ({1'b0, in_item_ff.first_index} == call_end);
      avail    = CntW'(SLOT_COUNT) - used_slots_ff;
      miss_a   = !found_a;
      miss_b   = in_item_ff.two_textures && !found_b;
      // second id needs one more free slot beyond the first
      need_b   = miss_b && ((avail == '0) || (miss_a && avail == CntW'(1)));
      create   = !join_ok || (miss_a && avail == '0) || need_b;

      if (create) begin
         sa       = '0;
         add_a    = 1'b1;
         used_mid = CntW'(1);
         add_b    = in_item_ff.two_textures;
         sb       = in_item_ff.two_textures ? CntW'(1) : '0;
      end else begin
         sa       = found_a ? pos_a : used_slots_ff;
         add_a    = miss_a;
         used_mid = used_slots_ff + CntW'(miss_a);
         add_b    = miss_b;
         sb       = !in_item_ff.two_textures ? '0 : (found_b ? pos_b : used_mid);
      end
      used_slots_in = used_mid + CntW'(add_b);

      wr_a   = advance && add_a;
      wr_b   = advance && add_b;
      adr_a  = sa;
      adr_b  = sb;
      data_b = in_item_ff.texture_b;

      count_base = create ? '0 : open_count_ff;
      count_sum  = {1'b0, count_base} + {1'b0, in_item_ff.index_total};

      open_valid_in = 1'b1;
      open_start_in = create ? in_item_ff.first_index : open_start_ff;
      open_cull_in  = create ? in_item_ff.cull_enable : open_cull_ff;
      // saturate the running count
      open_count_in = count_sum[IdxW] ? IdxMax : count_sum[IdxW-1:0];
   end

   assign sa_ext   = ExtW'(sa);
   assign sb_ext   = ExtW'(sb);
   assign used_ext = ExtW'(used_slots_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in                 = 1'b1;
         rsp_item_in.slot_a           = sa_ext[SlotW-1:0];
         rsp_item_in.slot_b           = sb_ext[SlotW-1:0];
         rsp_item_in.opened_call      = create;
         rsp_item_in.call_first_index = open_start_in;
         rsp_item_in.call_index_total = open_count_in;
         rsp_item_in.call_cull        = open_cull_in;
         rsp_item_in.slots_in_use     = used_ext[SlotW-1:0];
         rsp_item_in.added_texture_a  = add_a;
         rsp_item_in.added_texture_b  = add_b;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         used_slots_ff <= '0;
         open_valid_ff <= 1'b0;
         open_start_ff <= '0;
         open_count_ff <= '0;
         open_cull_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            used_slots_ff <= used_slots_in;
            open_valid_ff <= open_valid_in;
            open_start_ff <= open_start_in;
            open_count_ff <= open_count_in;
            open_cull_ff  <= open_cull_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   // slot table: up to two writes per word, never to the same slot
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (wr_a && adr_a[AdrW-1:0] == AdrW'(i)) begin
            slot_table_ff[i] <= in_item_ff.texture_a;
         end
         if (wr_b && adr_b[AdrW-1:0] == AdrW'(i)) begin
            slot_table_ff[i] <= data_b;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_item_ff.added_texture_b, rsp_item_ff.added_texture_a,
                        rsp_item_ff.slots_in_use, rsp_item_ff.call_cull,
                        rsp_item_ff.call_index_total, rsp_item_ff.call_first_index,
                        rsp_item_ff.opened_call, rsp_item_ff.slot_b, rsp_item_ff.slot_a};

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_slots_ff <= CntW'(SLOT_COUNT))
      else $error("occupied slot count beyond table size");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !open_valid_ff |-> (used_slots_ff == '0))
      else $error("slots occupied without an open call");

   a_single_tex: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_item_ff.two_textures) |=>
         (rsp_item_ff.slot_b == '0 && !rsp_item_ff.added_texture_b))
      else $error("second slot reported for a single texture batch");

   a_open_slots: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.opened_call) |->
         (rsp_item_ff.slots_in_use == SlotW'(1) || rsp_item_ff.slots_in_use == SlotW'(2)))
      else $error("new call opened with wrong slot count");

endmodule

// File: sim/tb_draw_call_sampler_slot_merger_unit.sv
`timescale 1ns / 100ps

module tb_draw_call_sampler_slot_merger_unit;
   import dcsm_pkg::*;

   localparam int SlotCount = SlotCountDefault;
   localparam int PoolSize  = 24;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   // [0] cull_enable, [1] two_textures, [32:2] texture_a, [63:33] texture_b,
   // [87:64] first_index, [111:88] index_total
   logic [ReqDataW-1:0] req_tdata = '0;
   // [0] first_batch
   logic [ReqUserW-1:0] req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // [3:0] slot_a, [7:4] slot_b, [8] opened_call, [32:9] call_first_index,
   // [56:33] call_index_total, [57] call_cull, [61:58] slots_in_use,
   // [62] added_texture_a, [63] added_texture_b
   logic [RspDataW-1:0] rsp_tdata;

   // merge state of the predictor
   logic [TexW-1:0] slot_ids [SlotCount];
   int unsigned     slots_used = 0;
   bit              call_open = 1'b0;
   logic [IdxW-1:0] call_start = '0;
   logic [IdxW-1:0] call_count = '0;
   bit              call_cull_q = 1'b0;

   logic [TexW-1:0] texture_pool [PoolSize];
   result_type      pending_results [$];
   int              mismatches = 0;
   bit              steady = 1'b0;

   draw_call_sampler_slot_merger_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("draw_call_sampler_slot_merger_unit regression: fail");
      $finish;
   end

   // stall the result side in short bursts until the steady phase
   initial begin : rsp_stall
      int burst;
      forever begin
         @(negedge clock);
         if (!steady && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 3);
            rsp_tready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int lookup_slot(logic [TexW-1:0] id);
      for (int i = 0; i < slots_used && i < SlotCount; i++) begin
         if (slot_ids[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic logic [IdxW:0] follow_sum();
      return {1'b0, call_start} + {1'b0, call_count};
   endfunction

   // merge one batch into the open call and return the word it produces
   function automatic result_type merge_batch(batch_type b);
      result_type      r;
      int              fa;
      int              fb;
      int unsigned     room;
      int unsigned     need;
      bit              reopen;
      logic [IdxW:0]   total;
      r = '0;
      reopen = 1'b1;
      fa = -1;
      fb = -1;
      need = 0;
      if (call_open && !b.first_batch && call_cull_q == b.cull_enable &&
          {1'b0, b.first_index} == follow_sum()) begin
         room = (slots_used < SlotCount) ? SlotCount - slots_used : 0;
         reopen = 1'b0;
         fa = lookup_slot(b.texture_a);
         if (fa < 0) begin
            if (room != 0) need++;
            else reopen = 1'b1;
         end
         // second id is looked up before the first one is inserted
         if (!reopen && b.two_textures) begin
            fb = lookup_slot(b.texture_b);
            if (fb < 0) begin
               if (need < room) need++;
               else reopen = 1'b1;
            end
         end
         if (!reopen) begin
            if (fa >= 0) begin
               r.slot_a = fa[SlotW-1:0];
            end else begin
               slot_ids[slots_used] = b.texture_a;
               r.slot_a = slots_used[SlotW-1:0];
               slots_used++;
               r.added_texture_a = 1'b1;
            end
            if (b.two_textures) begin
               if (fb >= 0) begin
                  r.slot_b = fb[SlotW-1:0];
               end else begin
                  slot_ids[slots_used] = b.texture_b;
                  r.slot_b = slots_used[SlotW-1:0];
                  slots_used++;
                  r.added_texture_b = 1'b1;
               end
            end
         end
      end
      if (reopen) begin
         r.opened_call = 1'b1;
         call_open = 1'b1;
         call_start = b.first_index;
         call_count = '0;
         call_cull_q = b.cull_enable;
         slot_ids[0] = b.texture_a;
         r.slot_a = '0;
         r.added_texture_a = 1'b1;
         slots_used = 1;
         if (b.two_textures) begin
            slot_ids[1] = b.texture_b;
            r.slot_b = 4'd1;
            r.added_texture_b = 1'b1;
            slots_used = 2;
         end
      end
      total = {1'b0, call_count} + {1'b0, b.index_total};
      call_count = total[IdxW] ? IdxMax : total[IdxW-1:0];
      r.call_first_index = call_start;
      r.call_index_total = call_count;
      r.call_cull = call_cull_q;
      r.slots_in_use = slots_used[SlotW-1:0];
      return r;
   endfunction

   task automatic send_batch(batch_type b);
      int gap;
      if (!steady && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= b.first_batch;
      req_tdata <= {b.index_total, b.first_index, b.texture_b, b.texture_a,
                    b.two_textures, b.cull_enable};
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_results.push_back(merge_batch(b));
   endtask

   task automatic issue(int first, int cull, int two, logic [TexW-1:0] ta,
                        logic [TexW-1:0] tb, logic [IdxW-1:0] start,
                        logic [IdxW-1:0] cnt);
      batch_type b;
      b.first_batch = first[0];
      b.cull_enable = cull[0];
      b.two_textures = two[0];
      b.texture_a = ta;
      b.texture_b = tb;
      b.first_index = start;
      b.index_total = cnt;
      send_batch(b);
   endtask

   function automatic logic [IdxW-1:0] follow_index();
      logic [IdxW:0] s;
      s = follow_sum();
      return s[IdxW-1:0];
   endfunction

   function automatic logic [TexW-1:0] pick_texture();
      if ($urandom_range(0, 39) == 0)
         texture_pool[$urandom_range(0, PoolSize - 1)] = TexW'($urandom());
      if ($urandom_range(0, 3) == 0) return TexW'($urandom());
      return texture_pool[$urandom_range(0, PoolSize - 1)];
   endfunction

   // mostly follow-on batches of the open call, with breaks and noise
   function automatic batch_type random_batch();
      batch_type     b;
      logic [IdxW:0] s;
      b.first_batch = ($urandom_range(0, 29) == 0);
      b.cull_enable = ($urandom_range(0, 11) == 0) ? ~call_cull_q : call_cull_q;
      b.two_textures = 1'($urandom_range(0, 1));
      b.texture_a = pick_texture();
      b.texture_b = pick_texture();
      s = follow_sum();
      if (s[IdxW] || $urandom_range(0, 9) == 0) b.first_index = IdxW'($urandom());
      else b.first_index = s[IdxW-1:0];
      if ($urandom_range(0, 49) == 0) b.index_total = IdxW'($urandom());
      else b.index_total = IdxW'($urandom_range(0, 300));
      return b;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.slot_a = rsp_tdata[3:0];
         got.slot_b = rsp_tdata[7:4];
         got.opened_call = rsp_tdata[8];
         got.call_first_index = rsp_tdata[32:9];
         got.call_index_total = rsp_tdata[56:33];
         got.call_cull = rsp_tdata[57];
         got.slots_in_use = rsp_tdata[61:58];
         got.added_texture_a = rsp_tdata[62];
         got.added_texture_b = rsp_tdata[63];
         if (pending_results.size() == 0) begin
            $display("%0t: rsp word expected none actual %0h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("slot_a", 32'(want.slot_a), 32'(got.slot_a));
            check_field("slot_b", 32'(want.slot_b), 32'(got.slot_b));
            check_field("opened_call", 32'(want.opened_call), 32'(got.opened_call));
            check_field("call_first_index", 32'(want.call_first_index),
                        32'(got.call_first_index));
            check_field("call_index_total", 32'(want.call_index_total),
                        32'(got.call_index_total));
            check_field("call_cull", 32'(want.call_cull), 32'(got.call_cull));
            check_field("slots_in_use", 32'(want.slots_in_use), 32'(got.slots_in_use));
            check_field("added_texture_a", 32'(want.added_texture_a),
                        32'(got.added_texture_a));
            check_field("added_texture_b", 32'(want.added_texture_b),
                        32'(got.added_texture_b));
         end
      end
   end

   task automatic test_open_rules();
      // no open call after reset
      issue(0, 0, 0, '0, '0, '0, '0);
      issue(0, 0, 1, '0, '1, follow_index(), 24'd5);
      // both ids new and equal take two slots
      issue(0, 0, 1, 31'd7, 31'd7, follow_index(), 24'd9);
      issue(0, 1, 0, 31'd7, '0, follow_index(), 24'd3);
      issue(0, 1, 1, 31'd8, 31'd7, follow_index() + 24'd1, 24'd4);
      issue(1, 1, 1, 31'd8, 31'd7, follow_index(), 24'd2);
   endtask

   task automatic test_slot_fill();
      issue(1, 0, 1, 31'd100, 31'd101, 24'h000400, 24'd16);
      for (int k = 0; k < 6; k++)
         issue(0, 0, 1, TexW'(102 + 2 * k), TexW'(103 + 2 * k), follow_index(), 24'd16);
      // one slot left: a reused id and one new id fit
      issue(0, 0, 1, 31'd100, 31'd200, follow_index(), 24'd16);
      issue(0, 0, 1, 31'd101, 31'd102, follow_index(), 24'd16);
      // table full: a new id opens a call
      issue(0, 0, 0, 31'd300, '0, follow_index(), 24'd16);
      for (int k = 0; k < 6; k++)
         issue(0, 0, 1, TexW'(400 + 2 * k), TexW'(401 + 2 * k), follow_index(), 24'd1);
      issue(0, 0, 0, 31'd500, '0, follow_index(), 24'd1);
      // one slot left but two new ids
      issue(0, 0, 1, 31'd600, 31'd601, follow_index(), 24'd1);
   endtask

   task automatic test_count_saturation();
      issue(1, 1, 0, '1, '0, '0, 24'hFFFFF0);
      issue(0, 1, 0, '1, '0, follow_index(), 24'h000100);
      // saturated count still sets the follow-on start
      issue(0, 1, 0, '1, '0, IdxMax, IdxMax);
      issue(0, 0, 1, '1, '1, IdxMax, IdxMax);
   endtask

   task automatic test_random_stream(int count);
      for (int n = 0; n < count; n++) send_batch(random_batch());
   endtask

   initial begin
      for (int i = 0; i < PoolSize; i++)
         texture_pool[i] = (i < 8) ? TexW'(i) : TexW'($urandom());
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_open_rules();
      test_slot_fill();
      test_count_saturation();
      test_random_stream(880);
      // back-to-back words with no idling on either side
      steady = 1'b1;
      test_random_stream(200);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("draw_call_sampler_slot_merger_unit regression: pass");
      end else begin
         $display("draw_call_sampler_slot_merger_unit regression: fail");
      end
      $finish;
   end

endmodule
